### sv/dpb_pkg.sv
package dpb_pkg;

  // Largest value the 13-bit frame width register can hold.
  localparam int FRAME_WIDTH_CAP = 8191;

  localparam int MAX_FRAME_WIDTH_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam int ROW_W   = 12;
  localparam int COORD_W = 20;

  localparam logic [12:0] FRAME_WIDTH_RST       = 13'd640;
  localparam logic [3:0]  GRID_STEP_RST         = 4'd3;
  localparam logic [31:0] DEPTH_RANGE_RST       = 32'h012C_1770;
  localparam logic [47:0] FOCAL_RECIPROCALS_RST = 48'h006D3A_006D3A;
  localparam logic [31:0] PRINCIPAL_POINT_RST   = 32'h1400_0F00;
  localparam logic [63:0] POSE_ROW_X_RST        = 64'h4000_0000_0000_0000;
  localparam logic [63:0] POSE_ROW_Y_RST        = 64'h0000_4000_0000_0000;
  localparam logic [63:0] POSE_ROW_Z_RST        = 64'h0000_0000_4000_0000;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH       = 3'd0,
    REG_GRID_STEP         = 3'd1,
    REG_DEPTH_RANGE       = 3'd2,
    REG_FOCAL_RECIPROCALS = 3'd3,
    REG_PRINCIPAL_POINT   = 3'd4,
    REG_POSE_ROW_X        = 3'd5,
    REG_POSE_ROW_Y        = 3'd6,
    REG_POSE_ROW_Z        = 3'd7
  } dpb_reg_e;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [3:0]  grid_step;
    logic [15:0] depth_min;
    logic [15:0] depth_max;
    logic [15:0] cx;
    logic [15:0] cy;
  } dpb_front_cfg_t;

  typedef struct packed {
    logic [23:0]      rfx;
    logic [23:0]      rfy;
    logic [2:0][63:0] pose;
  } dpb_back_cfg_t;

  // Column counter width for a given frame width limit.
  function automatic int dpb_col_w(int max_w);
    return $clog2((max_w < FRAME_WIDTH_CAP) ? max_w : FRAME_WIDTH_CAP);
  endfunction

  // Width of the signed Q.4 offset from the principal point.
  function automatic int dpb_du_w(int col_w);
    return (((col_w + 4) > 16) ? (col_w + 4) : 16) + 1;
  endfunction

endpackage

### sv/dpb_front.sv
module dpb_front
  import dpb_pkg::*;
#(
  parameter int MAX_FRAME_WIDTH = MAX_FRAME_WIDTH_DEF,
  parameter int COL_W           = dpb_col_w(MAX_FRAME_WIDTH),
  parameter int DU_W            = dpb_du_w(COL_W)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dpb_front_cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  frame_start_i,
  input  logic [15:0]           depth_i,
  input  logic [23:0]           rgb_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output logic [2*DU_W+39:0]    push_data_o
);

  localparam int EFF_MAX = (MAX_FRAME_WIDTH < FRAME_WIDTH_CAP) ? MAX_FRAME_WIDTH
                                                             : FRAME_WIDTH_CAP;

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [3:0]       cp_q, cp_d, cp_cur;
  logic [3:0]       rp_q, rp_d, rp_cur;
  logic [13:0]      width_eff;
  logic [4:0]       stride_eff;
  logic             accept, keep;
  logic signed [DU_W-1:0] du, dv;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_i.frame_width == 13'd0) begin
      width_eff = 14'd1;
    end else if (32'(cfg_i.frame_width) > EFF_MAX) begin
      width_eff = 14'(EFF_MAX);
    end else begin
      width_eff = {1'b0, cfg_i.frame_width};
    end
    stride_eff = (cfg_i.grid_step == 4'd0) ? 5'd1 : {1'b0, cfg_i.grid_step};
  end

  // A frame start puts this pixel at the origin before it is used.
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign cp_cur  = frame_start_i ? '0 : cp_q;
  assign rp_cur  = frame_start_i ? '0 : rp_q;

  assign keep = (cp_cur == 4'd0) && (rp_cur == 4'd0) && (depth_i != 16'd0) &&
                (depth_i >= cfg_i.depth_min) && (depth_i <= cfg_i.depth_max);

  always_comb begin
    if (14'(col_cur) + 14'd1 >= width_eff) begin
      col_d = '0;
      cp_d  = '0;
      row_d = row_cur + 1'b1;
      rp_d  = ({1'b0, rp_cur} + 5'd1 >= stride_eff) ? 4'd0 : rp_cur + 4'd1;
    end else begin
      col_d = col_cur + 1'b1;
      cp_d  = ({1'b0, cp_cur} + 5'd1 >= stride_eff) ? 4'd0 : cp_cur + 4'd1;
      row_d = row_cur;
      rp_d  = rp_cur;
    end
  end

  assign du = DU_W'({col_cur, 4'b0000}) - DU_W'(cfg_i.cx);
  assign dv = DU_W'({row_cur, 4'b0000}) - DU_W'(cfg_i.cy);

  assign push_o      = accept && keep;
  assign push_data_o = {du, dv, depth_i, rgb_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cp_q  <= '0;
      rp_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      cp_q  <= cp_d;
      rp_q  <= rp_d;
    end
  end

endmodule

### sv/dpb_queue.sv
module dpb_queue
  import dpb_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### sv/dpb_back.sv
module dpb_back
  import dpb_pkg::*;
#(
  parameter int DU_W = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dpb_back_cfg_t             cfg_i,
  input  logic                      in_valid_i,
  input  logic [2*DU_W+39:0]        in_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COORD_W-1:0]        out_x_o,
  output logic [COORD_W-1:0]        out_y_o,
  output logic [COORD_W-1:0]        out_z_o,
  output logic [23:0]               out_rgb_o
);

  localparam int P1_W  = DU_W + 17;
  localparam int P2_W  = P1_W + 25;
  localparam int XC_W  = P1_W + 1;
  localparam int M_W   = XC_W + 16;
  localparam int ACC_W = M_W + 2;
  localparam int RND_W = ACC_W - 18;

  logic [5:0] vld_q;
  logic [5:0] en;

  logic signed [DU_W-1:0] in_du, in_dv;
  logic [15:0]            in_z;
  logic [23:0]            in_rgb;

  logic signed [P1_W-1:0] s1_px_q, s1_py_q;
  logic [15:0]            s1_z_q;
  logic [23:0]            s1_rgb_q;
  logic signed [P2_W-1:0] s2_qx_q, s2_qy_q;
  logic [15:0]            s2_z_q;
  logic [23:0]            s2_rgb_q;
  logic signed [XC_W-1:0] s3_xc_q, s3_yc_q;
  logic [15:0]            s3_z_q;
  logic [23:0]            s3_rgb_q;
  logic signed [M_W-1:0]  s4_m_q [3][3];
  logic [23:0]            s4_rgb_q;
  logic signed [ACC_W-1:0] s5_acc_q [3];
  logic [23:0]            s5_rgb_q;
  logic [COORD_W-1:0]     out_q [3];
  logic [23:0]            out_rgb_q;

  logic signed [16:0]     z_s;
  logic signed [24:0]     rfx_s, rfy_s;
  logic signed [P2_W-1:0] qx_rnd, qy_rnd;
  logic signed [20:0]     zc_s;
  logic signed [15:0]     rot [3][3];
  logic signed [15:0]     trans [3];
  logic signed [ACC_W-1:0] acc_d [3];
  logic [COORD_W-1:0]     sat_d [3];

  assign {in_du, in_dv, in_z, in_rgb} = in_data_i;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    en[5] = !vld_q[5] || out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pop_o       = in_valid_i && en[0];
  assign out_valid_o = vld_q[5];

  assign z_s    = $signed({1'b0, in_z});
  assign rfx_s  = $signed({1'b0, cfg_i.rfx});
  assign rfy_s  = $signed({1'b0, cfg_i.rfy});
  assign qx_rnd = s2_qx_q + (P2_W'(1) << 23);
  assign qy_rnd = s2_qy_q + (P2_W'(1) << 23);
  assign zc_s   = $signed({1'b0, s3_z_q, 4'b0000});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        rot[a][j] = cfg_i.pose[a][63-16*j -: 16];
      end
      trans[a] = cfg_i.pose[a][15:0];
    end
  end

  // Rounding to mm with half up, then saturation to the coordinate range.
  always_comb begin
    logic signed [RND_W-1:0] rnd;
    rnd = '0;
    for (int a = 0; a < 3; a++) begin
      acc_d[a] = s5_acc_q[a] + (ACC_W'(1) << 17);
      rnd      = acc_d[a][ACC_W-1:18];
      if (rnd[RND_W-1:COORD_W-1] == '0 || rnd[RND_W-1:COORD_W-1] == '1) begin
        sat_d[a] = rnd[COORD_W-1:0];
      end else if (rnd[RND_W-1]) begin
        sat_d[a] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat_d[a] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 6; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_px_q  <= in_du * z_s;
      s1_py_q  <= in_dv * z_s;
      s1_z_q   <= in_z;
      s1_rgb_q <= in_rgb;
    end
    if (en[1]) begin
      s2_qx_q  <= s1_px_q * rfx_s;
      s2_qy_q  <= s1_py_q * rfy_s;
      s2_z_q   <= s1_z_q;
      s2_rgb_q <= s1_rgb_q;
    end
    if (en[2]) begin
      s3_xc_q  <= qx_rnd[P2_W-1:24];
      s3_yc_q  <= qy_rnd[P2_W-1:24];
      s3_z_q   <= s2_z_q;
      s3_rgb_q <= s2_rgb_q;
    end
    if (en[3]) begin
      for (int a = 0; a < 3; a++) begin
        s4_m_q[a][0] <= rot[a][0] * s3_xc_q;
        s4_m_q[a][1] <= rot[a][1] * s3_yc_q;
        s4_m_q[a][2] <= rot[a][2] * zc_s;
      end
      s4_rgb_q <= s3_rgb_q;
    end
    if (en[4]) begin
      for (int a = 0; a < 3; a++) begin
        s5_acc_q[a] <= ACC_W'(s4_m_q[a][0]) + ACC_W'(s4_m_q[a][1]) +
                       ACC_W'(s4_m_q[a][2]) + (ACC_W'(trans[a]) <<< 18);
      end
      s5_rgb_q <= s4_rgb_q;
    end
    if (en[5]) begin
      for (int a = 0; a < 3; a++) begin
        out_q[a] <= sat_d[a];
      end
      out_rgb_q <= s5_rgb_q;
    end
  end

  assign out_x_o   = out_q[0];
  assign out_y_o   = out_q[1];
  assign out_z_o   = out_q[2];
  assign out_rgb_o = out_rgb_q;

endmodule

### sv/depth_pixel_backprojector_top.sv
// Depth pixel back-projector. Depth pixels with their color arrive in raster
// order on the slave stream; the block counts column and row itself, keeps
// pixels on the stride grid whose depth is nonzero and within the configured
// range, back-projects them with pinhole intrinsics, moves them into world
// coordinates with a 3x4 pose, and sends each kept pixel as one point in
// millimeters, saturated to 20 bits, with its color. The block sustains one
// pixel per clock: a front end classifies each pixel in the cycle of its
// transfer, and a six-stage arithmetic pipeline behind a short queue turns
// kept pixels into points. A kept pixel passes the queue and the pipeline
// stages before its point is offered on the master side; the slave side
// stalls only when the queue fills because the master side is stalled.
// There is no clearing pass after reset. Configuration is to be written
// over the register port only while the stream is idle; nothing enforces it.
module depth_pixel_backprojector_top
  import dpb_pkg::*;
#(
  parameter int MAX_FRAME_WIDTH = MAX_FRAME_WIDTH_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata fields from bit 0: depth_mm[15:0], pix_red[23:16],
  // pix_green[31:24], pix_blue[39:32]
  input  logic [39:0] s_axis_tdata_i,
  // tuser fields from bit 0: frame_start[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata fields from bit 0: world_x_mm[19:0], world_y_mm[39:20],
  // world_z_mm[59:40], point_red[67:60], point_green[75:68],
  // point_blue[83:76], zero padding[87:84]
  output logic [87:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int COL_W = dpb_col_w(MAX_FRAME_WIDTH);
  localparam int DU_W  = dpb_du_w(COL_W);
  localparam int QW    = 2 * DU_W + 40;

  logic [12:0] frame_width_q;
  logic [3:0]  grid_step_q;
  logic [31:0] depth_range_q;
  logic [47:0] focal_q;
  logic [31:0] principal_q;
  logic [63:0] pose_x_q, pose_y_q, pose_z_q;

  dpb_reg_e       reg_sel;
  logic           cfg_wr;
  dpb_front_cfg_t front_cfg;
  dpb_back_cfg_t  back_cfg;

  logic          push, queue_full, queue_valid, pop;
  logic [QW-1:0] push_data, pop_data;
  logic [COORD_W-1:0] out_x, out_y, out_z;
  logic [23:0]        out_rgb;

  // Registers sit at eight-byte steps; the low address bits are ignored.
  assign reg_sel = dpb_reg_e'(paddr[5:3]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      grid_step_q    <= GRID_STEP_RST;
      depth_range_q  <= DEPTH_RANGE_RST;
      focal_q        <= FOCAL_RECIPROCALS_RST;
      principal_q    <= PRINCIPAL_POINT_RST;
      pose_x_q       <= POSE_ROW_X_RST;
      pose_y_q       <= POSE_ROW_Y_RST;
      pose_z_q       <= POSE_ROW_Z_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FRAME_WIDTH:       frame_width_q  <= pwdata[12:0];
        REG_GRID_STEP:         grid_step_q    <= pwdata[3:0];
        REG_DEPTH_RANGE:       depth_range_q  <= pwdata[31:0];
        REG_FOCAL_RECIPROCALS: focal_q        <= pwdata[47:0];
        REG_PRINCIPAL_POINT:   principal_q    <= pwdata[31:0];
        REG_POSE_ROW_X:        pose_x_q       <= pwdata;
        REG_POSE_ROW_Y:        pose_y_q       <= pwdata;
        REG_POSE_ROW_Z:        pose_z_q       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:       prdata = 64'(frame_width_q);
      REG_GRID_STEP:         prdata = 64'(grid_step_q);
      REG_DEPTH_RANGE:       prdata = 64'(depth_range_q);
      REG_FOCAL_RECIPROCALS: prdata = 64'(focal_q);
      REG_PRINCIPAL_POINT:   prdata = 64'(principal_q);
      REG_POSE_ROW_X:        prdata = pose_x_q;
      REG_POSE_ROW_Y:        prdata = pose_y_q;
      REG_POSE_ROW_Z:        prdata = pose_z_q;
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    front_cfg.frame_width  = frame_width_q;
    front_cfg.grid_step    = grid_step_q;
    front_cfg.depth_min    = depth_range_q[31:16];
    front_cfg.depth_max    = depth_range_q[15:0];
    front_cfg.cx           = principal_q[31:16];
    front_cfg.cy           = principal_q[15:0];
    back_cfg.rfx           = focal_q[47:24];
    back_cfg.rfy           = focal_q[23:0];
    back_cfg.pose[0]       = pose_x_q;
    back_cfg.pose[1]       = pose_y_q;
    back_cfg.pose[2]       = pose_z_q;
  end

  // The front end updates the raster position on every transfer and hands
  // only kept pixels, already offset from the principal point, to the queue.
  dpb_front #(
    .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
    .COL_W          (COL_W),
    .DU_W           (DU_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (front_cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .frame_start_i(s_axis_tuser_i),
    .depth_i      (s_axis_tdata_i[15:0]),
    .rgb_i        (s_axis_tdata_i[39:16]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  dpb_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .pop_data_o (pop_data)
  );

  // The back end scales by depth and the focal reciprocals, applies the
  // pose, rounds and saturates; its last stage is the output register.
  dpb_back #(
    .DU_W(DU_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (back_cfg),
    .in_valid_i (queue_valid),
    .in_data_i  (pop_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_z_o    (out_z),
    .out_rgb_o  (out_rgb)
  );

  // The color travels as red, green, blue from its lowest bit up, just as it
  // arrived on the slave side.
  assign m_axis_tdata_o = {4'b0000, out_rgb, out_z, out_y, out_x};

endmodule

### sv/dpb_checker.sv
module dpb_checker
  import dpb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [87:0] m_axis_tdata_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [5:0]  paddr_i,
  input logic [63:0] pwdata_i,
  input logic [63:0] prdata_i
);

  logic stride_wr;

  assign stride_wr = psel_i && penable_i && pwrite_i &&
                     (paddr_i[5:3] == REG_GRID_STEP);

  // A stalled point holds its value until the transfer completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("output point changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[87:84] == 4'b0000)
    else $error("output padding bits not zero");

  // Out of reset the queue is empty and the pipeline holds no point.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> s_axis_tready_i && !m_axis_tvalid_i)
    else $error("block not idle after reset");

  a_stride_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stride_wr ##1 (paddr_i[5:3] == REG_GRID_STEP) |->
      prdata_i == {60'd0, $past(pwdata_i[3:0])})
    else $error("stride register read back wrong value");

endmodule

bind depth_pixel_backprojector_top dpb_checker u_dpb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_i(s_axis_tready_o),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .psel_i         (psel),
  .penable_i      (penable),
  .pwrite_i       (pwrite),
  .paddr_i        (paddr),
  .pwdata_i       (pwdata),
  .prdata_i       (prdata)
);

### verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the depth pixel back-projector. A table of directed pixels and
// register writes comes first, then random frames under random register
// settings. Every accepted pixel runs through a predictor that keeps its own
// copy of the raster counters and registers; each point from the block is
// checked field by field against the oldest predicted point.
module tb_top;
  import dpb_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_PIXELS = 820;
  localparam longint COORD_MAX = 524287;
  localparam longint COORD_MIN = -524288;

  typedef struct packed {
    logic [19:0] x_mm;
    logic [19:0] y_mm;
    logic [19:0] z_mm;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  // One row of stimulus: either a pixel or a register write. A pixel row may
  // carry its expected point typed in, used in place of the predicted one.
  typedef struct {
    step_kind_e  kind;
    dpb_reg_e    reg_idx;
    logic [63:0] value;
    logic        frame_start;
    logic [15:0] depth;
    logic [23:0] rgb;
    bit          fixed;
    bit          fixed_hit;
    point_t      fixed_pt;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // Fields from bit 0: depth_mm[15:0], pix_red[23:16], pix_green[31:24],
  // pix_blue[39:32].
  logic [39:0] s_axis_tdata_i = '0;
  // Fields from bit 0: frame_start[0].
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // Fields from bit 0: world_x_mm[19:0], world_y_mm[39:20], world_z_mm[59:40],
  // point_red[67:60], point_green[75:68], point_blue[83:76], zeros[87:84].
  logic [87:0] m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  depth_pixel_backprojector_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and raster state of the predictor.
  logic [12:0] cfg_width;
  logic [3:0]  cfg_stride;
  logic [31:0] cfg_range;
  logic [47:0] cfg_focal;
  logic [31:0] cfg_center;
  logic [63:0] cfg_pose [3];
  int unsigned pix_col, pix_row, col_phase, row_phase;

  point_t pending_points[$];
  int     errors, pixels_sent, points_expected, points_checked, reg_writes, settings;
  int     random_sent;
  bit     steady, hold_req;

  // Shift right by s with the half rounded toward plus infinity.
  function automatic longint round_up_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // One world axis: rotation row times the camera point plus translation,
  // all in Q.18 mm, then rounded to mm and saturated to 20 bits.
  function automatic logic [19:0] axis_mm(input logic [63:0] pose, input longint xc,
                                          input longint yc, input longint zc);
    longint acc, mm;
    acc = longint'($signed(pose[63:48])) * xc + longint'($signed(pose[47:32])) * yc
        + longint'($signed(pose[31:16])) * zc + longint'($signed(pose[15:0])) * 262144;
    mm = round_up_shift(acc, 18);
    if (mm > COORD_MAX) mm = COORD_MAX;
    else if (mm < COORD_MIN) mm = COORD_MIN;
    return mm[19:0];
  endfunction

  // Predicts the point of one accepted pixel and advances the raster counters.
  function automatic bit project_pixel(input logic frame_start, input logic [15:0] depth,
                                       input logic [23:0] rgb, output point_t pt);
    int unsigned width, stride;
    longint du, dv, xc, yc, zc;
    bit kept;
    width = (cfg_width == 0) ? 1 : ((cfg_width > MAX_FRAME_WIDTH_DEF) ?
            MAX_FRAME_WIDTH_DEF : cfg_width);
    stride = (cfg_stride == 0) ? 1 : cfg_stride;
    if (frame_start) begin
      pix_col = 0;
      pix_row = 0;
      col_phase = 0;
      row_phase = 0;
    end
    kept = col_phase == 0 && row_phase == 0 && depth != 0 &&
           depth >= cfg_range[31:16] && depth <= cfg_range[15:0];
    pt = '0;
    if (kept) begin
      du = longint'(pix_col) * 16 - longint'(cfg_center[31:16]);
      dv = longint'(pix_row) * 16 - longint'(cfg_center[15:0]);
      xc = round_up_shift(du * longint'(depth) * longint'(cfg_focal[47:24]), 24);
      yc = round_up_shift(dv * longint'(depth) * longint'(cfg_focal[23:0]), 24);
      zc = longint'(depth) * 16;
      pt.x_mm  = axis_mm(cfg_pose[0], xc, yc, zc);
      pt.y_mm  = axis_mm(cfg_pose[1], xc, yc, zc);
      pt.z_mm  = axis_mm(cfg_pose[2], xc, yc, zc);
      pt.red   = rgb[23:16];
      pt.green = rgb[15:8];
      pt.blue  = rgb[7:0];
    end
    // A phase left at or above a new, smaller stride wraps on its next advance.
    if (pix_col + 1 >= width) begin
      pix_col = 0;
      col_phase = 0;
      pix_row = (pix_row + 1) & 32'hFFF;
      row_phase = (row_phase + 1 >= stride) ? 0 : row_phase + 1;
    end else begin
      pix_col++;
      col_phase = (col_phase + 1 >= stride) ? 0 : col_phase + 1;
    end
    return kept;
  endfunction

  function automatic step_t px(input logic frame_start, input logic [15:0] depth,
                               input logic [23:0] rgb);
    step_t s;
    s.kind = STEP_PIXEL;
    s.reg_idx = REG_FRAME_WIDTH;
    s.value = '0;
    s.frame_start = frame_start;
    s.depth = depth;
    s.rgb = rgb;
    s.fixed = 1'b0;
    s.fixed_hit = 1'b0;
    s.fixed_pt = '0;
    return s;
  endfunction

  // A pixel that must not produce a point.
  function automatic step_t px_none(input logic frame_start, input logic [15:0] depth);
    step_t s;
    s = px(frame_start, depth, 24'hA5_5A_C3);
    s.fixed = 1'b1;
    return s;
  endfunction

  // A pixel whose point is typed in.
  function automatic step_t px_fixed(input logic frame_start, input logic [15:0] depth,
                                     input logic [23:0] rgb, input int x, input int y,
                                     input int z);
    step_t s;
    s = px(frame_start, depth, rgb);
    s.fixed = 1'b1;
    s.fixed_hit = 1'b1;
    s.fixed_pt = {20'(x), 20'(y), 20'(z), rgb};
    return s;
  endfunction

  function automatic step_t wr(input dpb_reg_e idx, input logic [63:0] value);
    step_t s;
    s = px(1'b0, '0, '0);
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offers one pixel, idling at random first, and predicts once it transfers.
  task automatic send_pixel(input step_t s);
    bit hit;
    point_t pt;
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= s.frame_start;
    s_axis_tdata_i  <= {s.rgb[7:0], s.rgb[15:8], s.rgb[23:16], s.depth};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixels_sent++;
    hit = project_pixel(s.frame_start, s.depth, s.rgb, pt);
    if (s.fixed) begin
      hit = s.fixed_hit;
      pt = s.fixed_pt;
    end
    if (hit) begin
      pending_points = {pending_points, pt};
      points_expected++;
    end
  endtask

  // Setup and access phases, then idle, so that back to back writes
  // never drive the bus twice in one time step.
  task automatic reg_write(input dpb_reg_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:       cfg_width = value[12:0];
      REG_GRID_STEP:         cfg_stride = value[3:0];
      REG_DEPTH_RANGE:       cfg_range = value[31:0];
      REG_FOCAL_RECIPROCALS: cfg_focal = value[47:0];
      REG_PRINCIPAL_POINT:   cfg_center = value[31:0];
      REG_POSE_ROW_X:        cfg_pose[0] = value;
      REG_POSE_ROW_Y:        cfg_pose[1] = value;
      REG_POSE_ROW_Z:        cfg_pose[2] = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Stops offering pixels, waits for every predicted point, reports those that
  // never came, then idles for SETTLE_CYCLES before the next step.
  task automatic settle();
    int waited;
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    while (pending_points.size() != 0) begin
      $display("%0t: point missing, expected x=%0d y=%0d z=%0d, got none", $time,
               $signed(pending_points[0].x_mm), $signed(pending_points[0].y_mm),
               $signed(pending_points[0].z_mm));
      errors++;
      void'(pending_points.pop_front());
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : point_check
    point_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[83:0];
      got = {m_axis_tdata_o[19:0], m_axis_tdata_o[39:20], m_axis_tdata_o[59:40],
             m_axis_tdata_o[67:60], m_axis_tdata_o[75:68], m_axis_tdata_o[83:76]};
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, got x=%0d y=%0d z=%0d", $time,
                 $signed(got.x_mm), $signed(got.y_mm), $signed(got.z_mm));
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        check_field("world_x_mm", $signed(want.x_mm), $signed(got.x_mm));
        check_field("world_y_mm", $signed(want.y_mm), $signed(got.y_mm));
        check_field("world_z_mm", $signed(want.z_mm), $signed(got.z_mm));
        check_field("point_red", want.red, got.red);
        check_field("point_green", want.green, got.green);
        check_field("point_blue", want.blue, got.blue);
      end
    end
  end

  // Point sink. Stalls at random, once holds off for a long stretch so that
  // the queue fills and the pixel side stalls, and never stalls while the
  // stimulus asks for a steady stretch.
  initial begin : point_sink
    int hold_left;
    hold_left = -1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left < 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin : stimulus
    step_t       steps[$];
    logic [12:0] width;
    logic [3:0]  stride;
    logic [31:0] range;
    logic [63:0] pose;
    int          eff_width, frame_len, phase_len, k, i, pick;
    bit          open_frame;
    logic        fs;
    logic [15:0] depth;

    cfg_width   = FRAME_WIDTH_RST;
    cfg_stride  = GRID_STEP_RST;
    cfg_range   = DEPTH_RANGE_RST;
    cfg_focal   = FOCAL_RECIPROCALS_RST;
    cfg_center  = PRINCIPAL_POINT_RST;
    cfg_pose[0] = POSE_ROW_X_RST;
    cfg_pose[1] = POSE_ROW_Y_RST;
    cfg_pose[2] = POSE_ROW_Z_RST;
    pix_col = 0;
    pix_row = 0;
    col_phase = 0;
    row_phase = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: stride 3, depth 300 to 6000 mm. The stride grid, the
    // depth bounds and the zero depth come first.
    steps = {steps, px(1'b1, 16'd1000, 24'hFF_00_80)};
    steps = {steps, px_none(1'b0, 16'd1000)};
    steps = {steps, px_none(1'b0, 16'd1000)};
    steps = {steps, px(1'b0, 16'd1000, 24'h00_FF_7F)};
    steps = {steps, px_none(1'b1, 16'd0)};
    steps = {steps, px_none(1'b1, 16'd299)};
    steps = {steps, px(1'b1, 16'd300, 24'h12_34_56)};
    steps = {steps, px(1'b1, 16'd6000, 24'hED_CB_A9)};
    steps = {steps, px_none(1'b1, 16'd6001)};
    // Full range from zero: a zero depth is still dropped.
    steps = {steps, wr(REG_DEPTH_RANGE, 64'h0000_FFFF)};
    steps = {steps, px_none(1'b1, 16'd0)};
    // With the principal point at the origin the first pixel lies on the axis.
    steps = {steps, wr(REG_PRINCIPAL_POINT, 64'h0)};
    steps = {steps, px_fixed(1'b1, 16'hFFFF, 24'hFF_FF_FF, 0, 0, 65535)};
    // Zero width acts as one pixel per row and zero stride as a stride of one.
    steps = {steps, wr(REG_FRAME_WIDTH, 64'h0)};
    steps = {steps, wr(REG_GRID_STEP, 64'h0)};
    steps = {steps, px_fixed(1'b1, 16'd1, 24'h00_00_00, 0, 0, 1)};
    steps = {steps, px(1'b0, 16'd500, 24'h5A_A5_3C)};
    steps = {steps, px(1'b0, 16'd40000, 24'hC3_3C_96)};
    // An inverted range rejects everything.
    steps = {steps, wr(REG_DEPTH_RANGE, 64'hFFFF_0000)};
    steps = {steps, px_none(1'b1, 16'd1000)};
    steps = {steps, px_none(1'b0, 16'hFFFF)};
    // Largest offsets and focal reciprocals drive x and y into saturation;
    // a width beyond the limit is clamped.
    steps = {steps, wr(REG_FRAME_WIDTH, 64'd8191)};
    steps = {steps, wr(REG_DEPTH_RANGE, 64'h0001_FFFF)};
    steps = {steps, wr(REG_FOCAL_RECIPROCALS, 64'hFFFF_FFFF_FFFF)};
    steps = {steps, wr(REG_PRINCIPAL_POINT, 64'hFFFF_FFFF)};
    steps = {steps, px_fixed(1'b1, 16'hFFFF, 24'h80_40_20, -524288, -524288, 65535)};
    steps = {steps, wr(REG_POSE_ROW_X, 64'hC000_0000_0000_0000)};
    steps = {steps, px_fixed(1'b1, 16'hFFFF, 24'h01_02_04, 524287, -524288, 65535)};

    for (i = 0; i < steps.size(); i++) begin
      if (steps[i].kind == STEP_WRITE) begin
        settle();
        reg_write(steps[i].reg_idx, steps[i].value);
      end else begin
        send_pixel(steps[i]);
      end
    end

    // Random frames under random settings. Phases do not always open with a
    // frame start, so counters and phases carry across stride and width changes.
    while (random_sent < RANDOM_PIXELS) begin
      settle();
      settings++;
      case ($urandom_range(9))
        0:       width = 13'd0;
        1:       width = 13'd8191;
        2:       width = 13'd4096;
        3:       width = 13'($urandom_range(8190, 4097));
        default: width = 13'($urandom_range(24, 1));
      endcase
      case ($urandom_range(7))
        0:       stride = 4'd0;
        1:       stride = 4'd15;
        default: stride = 4'($urandom_range(4, 1));
      endcase
      case ($urandom_range(5))
        0:       range = 32'h0000_FFFF;
        1:       range = {16'($urandom_range(65535, 1000)), 16'($urandom_range(999, 0))};
        2:       range = $urandom;
        default: range = {16'($urandom_range(800, 0)), 16'($urandom_range(65535, 1500))};
      endcase
      reg_write(REG_FRAME_WIDTH, 64'(width));
      reg_write(REG_GRID_STEP, 64'(stride));
      reg_write(REG_DEPTH_RANGE, 64'(range));
      if ($urandom_range(1))
        reg_write(REG_FOCAL_RECIPROCALS, {16'h0, 24'($urandom_range(32768, 16384)),
                                          24'($urandom_range(32768, 16384))});
      else
        reg_write(REG_FOCAL_RECIPROCALS, {16'h0, 16'($urandom), 32'($urandom)});
      if ($urandom_range(1))
        reg_write(REG_PRINCIPAL_POINT, {32'h0, 16'($urandom_range(640, 0)),
                                        16'($urandom_range(160, 0))});
      else
        reg_write(REG_PRINCIPAL_POINT, {32'h0, 32'($urandom)});
      // Pose rows are either fully random or close to the identity.
      for (k = 0; k < 3; k++) begin
        pose = {32'($urandom), 32'($urandom)};
        if ($urandom_range(2) != 0) begin
          pose[63:16] = {3{16'($urandom_range(255, 0)) - 16'd128}};
          pose[63 - 16 * k -: 16] = 16'h3F00 + 16'($urandom_range(511, 0));
        end
        case (k)
          0:       reg_write(REG_POSE_ROW_X, pose);
          1:       reg_write(REG_POSE_ROW_Y, pose);
          default: reg_write(REG_POSE_ROW_Z, pose);
        endcase
      end

      eff_width = (width == 0) ? 1 : ((width > MAX_FRAME_WIDTH_DEF) ?
                  MAX_FRAME_WIDTH_DEF : int'(width));
      frame_len = eff_width * $urandom_range(6, 2);
      if (frame_len > 200) frame_len = 200;
      phase_len = $urandom_range(140, 60);
      open_frame = $urandom_range(99) < 75;
      for (k = 0; k < phase_len; k++) begin
        fs = ((k % frame_len) == 0 && (k != 0 || open_frame)) || ($urandom_range(99) < 3);
        pick = $urandom_range(99);
        if (pick < 70 && range[31:16] <= range[15:0])
          depth = 16'($urandom_range(range[15:0], range[31:16]));
        else if (pick < 80) depth = 16'd0;
        else if (pick < 85) depth = range[31:16];
        else if (pick < 90) depth = range[15:0];
        else depth = 16'($urandom);
        steady = random_sent >= 500 && random_sent < 650;
        if (random_sent == 250) hold_req = 1'b1;
        send_pixel(px(fs, depth, 24'($urandom)));
        random_sent++;
      end
    end
    steady = 1'b0;

    settle();
    $display("tb_top: %0d pixels over %0d random settings, %0d register writes",
             pixels_sent, settings, reg_writes);
    $display("tb_top: %0d points predicted, %0d points checked, %0d failures",
             points_expected, points_checked, errors);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // The slowest correct run stays far below this bound.
  initial begin : watchdog
    #5000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
